// ===== rtl/core/csp_pkg.sv =====
// Shared types, codes and character helpers for the colour string parser.
`default_nettype none

package csp_pkg;

   // parse phase codes
   localparam logic [3:0] PH_WS        = 4'd0;
   localparam logic [3:0] PH_MATCH_RGB = 4'd1;
   localparam logic [3:0] PH_MATCH_ARG = 4'd2;
   localparam logic [3:0] PH_NODIG     = 4'd3;
   localparam logic [3:0] PH_SKIP      = 4'd4;
   localparam logic [3:0] PH_TOKWS     = 4'd5;
   localparam logic [3:0] PH_ZERO      = 4'd6;
   localparam logic [3:0] PH_ZERO_X    = 4'd7;
   localparam logic [3:0] PH_PREFIX    = 4'd8;
   localparam logic [3:0] PH_PREFIX_WS = 4'd9;
   localparam logic [3:0] PH_DIGITS    = 4'd10;
   localparam logic [3:0] PH_TRAIL     = 4'd11;
   localparam logic [3:0] PH_DONE      = 4'd12;

   // number bases
   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_HEX = 2'd1;
   localparam logic [1:0] BASE_OCT = 2'd2;
   localparam logic [1:0] BASE_BIN = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRAILING  = 2'd1;
   localparam logic [1:0] ST_NO_DIGITS = 2'd2;
   localparam logic [1:0] ST_MALFORMED = 2'd3;

   // digit code meaning "not a digit"
   localparam logic [4:0] NO_DIGIT = 5'd16;

   localparam int RESULT_WIDTH = 32;

   typedef struct packed {
      logic                    valid;
      logic [RESULT_WIDTH-1:0] value;
      logic [1:0]              status;
   } csp_result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
   endfunction

   function automatic logic [4:0] radix_of(input logic [1:0] base);
      logic [4:0] r;
      case (base)
         BASE_DEC: r = 5'd10;
         BASE_HEX: r = 5'd16;
         BASE_OCT: r = 5'd8;
         default:  r = 5'd2;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] base);
      logic [7:0] l;
      logic [4:0] d;
      l = to_lower(c);
      d = NO_DIGIT;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 5'(c - 8'h30);
      end else if (l >= 8'h61 && l <= 8'h66) begin
         d = 5'(l - 8'h61 + 8'd10);
      end
      if (d >= radix_of(base)) begin
         d = NO_DIGIT;
      end
      return d;
   endfunction

   // expected prefix character at a position, "rgb(" or "argb("
   function automatic logic [7:0] pat_char(input logic is_argb, input logic [2:0] pos);
      logic [7:0] p;
      p = 8'h00;
      if (is_argb) begin
         case (pos)
            3'd0:    p = 8'h61;
            3'd1:    p = 8'h72;
            3'd2:    p = 8'h67;
            3'd3:    p = 8'h62;
            3'd4:    p = 8'h28;
            default: p = 8'h00;
         endcase
      end else begin
         case (pos)
            3'd0:    p = 8'h72;
            3'd1:    p = 8'h67;
            3'd2:    p = 8'h62;
            3'd3:    p = 8'h28;
            default: p = 8'h00;
         endcase
      end
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csp_digit_acc.sv =====
// Digit decode and saturating radix accumulate for one character.
`default_nettype none

module csp_digit_acc #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic [VALUE_WIDTH-1:0] value_in,
   input  wire logic [1:0]             base,
   input  wire logic [7:0]             char_code,
   output logic                        digit_valid,
   output logic [VALUE_WIDTH-1:0]      acc_value
);
   import csp_pkg::*;

   localparam int PW = VALUE_WIDTH + 4;

   logic [4:0]    digit;
   logic [PW-1:0] v_ext;
   logic [PW-1:0] scaled;
   logic [PW-1:0] sum;

   assign digit       = digit_of(char_code, base);
   assign digit_valid = (digit != NO_DIGIT);
   assign v_ext       = PW'(value_in);

   always_comb begin
      case (base)
         BASE_DEC: scaled = (v_ext << 3) + (v_ext << 1);
         BASE_HEX: scaled = v_ext << 4;
         BASE_OCT: scaled = v_ext << 3;
         default:  scaled = v_ext << 1;
      endcase
   end

   assign sum = scaled + PW'(digit[3:0]);

   // saturate when the scaled value plus digit spills past the value width
   assign acc_value = (sum[PW-1:VALUE_WIDTH] != 4'd0) ? '1 : sum[VALUE_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/csp_step.sv =====
// Parse state registers and per-character next-state and result logic.
`default_nettype none

module csp_step #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enable,
   input  wire logic [7:0]              char_code,
   input  wire logic                    last_char,
   output csp_pkg::csp_result_type      result
);
   import csp_pkg::*;

   logic [3:0]             phase_ff,     phase_in;
   logic [2:0]             prefix_ff,    prefix_in;
   logic [VALUE_WIDTH-1:0] packed_ff,    packed_in;
   logic [VALUE_WIDTH-1:0] comp_ff,      comp_in;
   logic [2:0]             index_ff,     index_in;
   logic [1:0]             base_ff,      base_in;
   logic                   seen_ff,      seen_in;
   logic                   error_ff,     error_in;

   logic                   start_ctx;
   logic [VALUE_WIDTH-1:0] acc_src;
   logic [1:0]             acc_base;
   logic                   dig_ok;
   logic [VALUE_WIDTH-1:0] acc_value;

   assign start_ctx = (phase_ff == PH_WS) || (phase_ff == PH_SKIP) || (phase_ff == PH_TOKWS);
   assign acc_src   = start_ctx ? '0 : comp_ff;
   assign acc_base  = start_ctx ? BASE_DEC : ((phase_ff == PH_ZERO_X) ? BASE_HEX : base_ff);

   csp_digit_acc #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_digit_acc (
      .value_in    (acc_src),
      .base        (acc_base),
      .char_code   (char_code),
      .digit_valid (dig_ok),
      .acc_value   (acc_value)
   );

   always_comb begin
      logic [3:0]             ph;
      logic [2:0]             pp;
      logic [VALUE_WIDTH-1:0] pk;
      logic [VALUE_WIDTH-1:0] cv;
      logic [2:0]             ci;
      logic [1:0]             nb;
      logic                   ds;
      logic                   ef;
      logic                   fin;
      logic                   do_start;
      logic                   last_comp;
      logic [7:0]             lc;
      logic [7:0]             delim;
      logic [2:0]             pp_inc;
      logic [2:0]             plen;
      logic                   argb;

      ph = phase_ff;
      pp = prefix_ff;
      pk = packed_ff;
      cv = comp_ff;
      ci = index_ff;
      nb = base_ff;
      ds = seen_ff;
      ef = error_ff;
      fin = 1'b0;
      do_start = 1'b0;
      lc = to_lower(char_code);
      last_comp = ({1'b0, index_ff} + 4'd2) == {1'b0, prefix_ff};
      delim = last_comp ? 8'h29 : 8'h2C;
      argb = (phase_ff == PH_MATCH_ARG);
      plen = argb ? 3'd5 : 3'd4;
      pp_inc = prefix_ff + 3'd1;

      case (phase_ff) inside
         PH_WS: begin
            if (!is_space(char_code)) begin
               if (lc == 8'h72) begin
                  ph = PH_MATCH_RGB;
                  pp = 3'd1;
               end else if (lc == 8'h61) begin
                  ph = PH_MATCH_ARG;
                  pp = 3'd1;
               end else begin
                  do_start = 1'b1;
               end
            end
         end
         PH_MATCH_RGB, PH_MATCH_ARG: begin
            if (lc == pat_char(argb, prefix_ff)) begin
               pp = pp_inc;
               if (pp_inc >= plen) begin
                  pp = plen;
                  ph = PH_SKIP;
                  ci = 3'd0;
               end
            end else begin
               pp = 3'd0;
               ph = PH_NODIG;
            end
         end
         PH_SKIP: begin
            if (char_code != delim) begin
               ph = PH_TOKWS;
               if (!is_space(char_code)) begin
                  do_start = 1'b1;
               end
            end
         end
         PH_TOKWS: begin
            if (char_code == delim) begin
               fin = 1'b1;
            end else if (!is_space(char_code)) begin
               do_start = 1'b1;
            end
         end
         PH_ZERO, PH_ZERO_X, PH_PREFIX, PH_PREFIX_WS, PH_DIGITS, PH_TRAIL: begin
            if (prefix_ff != 3'd0 && char_code == delim) begin
               fin = 1'b1;
            end else begin
               case (phase_ff) inside
                  PH_ZERO: begin
                     if (lc == 8'h78) begin
                        ph = PH_ZERO_X;
                     end else if (dig_ok) begin
                        cv = acc_value;
                        ds = 1'b1;
                        ph = PH_DIGITS;
                     end else begin
                        ph = PH_TRAIL;
                     end
                  end
                  PH_ZERO_X: begin
                     if (dig_ok) begin
                        nb = BASE_HEX;
                        cv = acc_value;
                        ds = 1'b1;
                        ph = PH_DIGITS;
                     end else begin
                        ph = PH_TRAIL;
                     end
                  end
                  PH_PREFIX, PH_PREFIX_WS: begin
                     if (is_space(char_code)) begin
                        ph = PH_PREFIX_WS;
                     end else if (dig_ok) begin
                        cv = acc_value;
                        ds = 1'b1;
                        ph = PH_DIGITS;
                     end else begin
                        ph = PH_TRAIL;
                     end
                  end
                  PH_DIGITS: begin
                     if (dig_ok) begin
                        cv = acc_value;
                        ds = 1'b1;
                     end else begin
                        ph = PH_TRAIL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      if (do_start) begin
         cv = '0;
         ds = 1'b0;
         nb = BASE_DEC;
         if (char_code == 8'h30) begin
            ds = 1'b1;
            ph = PH_ZERO;
         end else if (lc == 8'h78) begin
            nb = BASE_HEX;
            ph = PH_PREFIX;
         end else if (lc == 8'h6F) begin
            nb = BASE_OCT;
            ph = PH_PREFIX;
         end else if (lc == 8'h62) begin
            nb = BASE_BIN;
            ph = PH_PREFIX;
         end else if (char_code >= 8'h31 && char_code <= 8'h39) begin
            cv = acc_value;
            ds = 1'b1;
            ph = PH_DIGITS;
         end else begin
            ph = PH_TRAIL;
         end
      end

      // end of string closes the last component
      if (last_char && pp != 3'd0 && !ef && ph != PH_DONE && ph != PH_SKIP &&
          ph != PH_WS && ph != PH_MATCH_RGB && ph != PH_MATCH_ARG && ph != PH_NODIG &&
          (({1'b0, ci} + 4'd2) == {1'b0, pp})) begin
         fin = 1'b1;
      end

      if (fin) begin
         if (ph == PH_DIGITS || ph == PH_ZERO || ph == PH_PREFIX || ph == PH_TOKWS) begin
            pk = (pk << 8) + cv;
            ph = ((({1'b0, ci} + 4'd2) == {1'b0, pp})) ? PH_DONE : PH_SKIP;
            ci = ci + 3'd1;
            cv = '0;
            ds = 1'b0;
            nb = BASE_DEC;
         end else begin
            ef = 1'b1;
            ph = PH_DONE;
         end
      end

      result.valid = last_char;
      if (ph == PH_WS || ph == PH_MATCH_RGB || ph == PH_MATCH_ARG || ph == PH_NODIG) begin
         result.value  = '0;
         result.status = ST_NO_DIGITS;
      end else if (pp != 3'd0) begin
         if (!ef && ph == PH_DONE) begin
            result.value  = RESULT_WIDTH'(pk);
            result.status = ST_OK;
         end else begin
            result.value  = '0;
            result.status = ST_MALFORMED;
         end
      end else begin
         result.value = RESULT_WIDTH'(cv);
         if (ph == PH_DIGITS || ph == PH_ZERO) begin
            result.status = ST_OK;
         end else if (ph == PH_ZERO_X) begin
            result.status = ST_TRAILING;
         end else if (ph == PH_TRAIL) begin
            result.status = ds ? ST_TRAILING : ST_NO_DIGITS;
         end else begin
            result.status = ST_NO_DIGITS;
         end
      end

      if (last_char) begin
         phase_in  = PH_WS;
         prefix_in = 3'd0;
         packed_in = '0;
         comp_in   = '0;
         index_in  = 3'd0;
         base_in   = BASE_DEC;
         seen_in   = 1'b0;
         error_in  = 1'b0;
      end else begin
         phase_in  = ph;
         prefix_in = pp;
         packed_in = pk;
         comp_in   = cv;
         index_in  = ci;
         base_in   = nb;
         seen_in   = ds;
         error_in  = ef;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WS;
         prefix_ff <= 3'd0;
         packed_ff <= '0;
         comp_ff   <= '0;
         index_ff  <= 3'd0;
         base_ff   <= BASE_DEC;
         seen_ff   <= 1'b0;
         error_ff  <= 1'b0;
      end else if (enable) begin
         phase_ff  <= phase_in;
         prefix_ff <= prefix_in;
         packed_ff <= packed_in;
         comp_ff   <= comp_in;
         index_ff  <= index_in;
         base_ff   <= base_in;
         seen_ff   <= seen_in;
         error_ff  <= error_in;
      end
   end

   a_restart_after_last : assert property (@(posedge clock) disable iff (reset)
      (enable && last_char) |=> (phase_ff == PH_WS && prefix_ff == 3'd0 && !error_ff))
      else $error("parse state not cleared after final character");

   a_prefix_len : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP || phase_ff == PH_DONE) |->
      (prefix_ff == 3'd4 || prefix_ff == 3'd5 || prefix_ff == 3'd0))
      else $error("prefix position out of range in component mode");

   a_idle_hold : assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(phase_ff) && $stable(packed_ff) && $stable(comp_ff))
      else $error("parse state moved without a character");

endmodule

`default_nettype wire

// ===== rtl/core/color_string_parser.sv =====
// Colour string parser top level: input register, parse step, result register.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------
//   req_     | in        | req_valid/req_stall | req_char_code, req_last_char
//   rsp_     | out       | rsp_valid/rsp_stall | rsp_color_value, rsp_parse_status
//
// One character per clock unless req_stall is high; a final character passes the input register,
// the combinational parse step and the result register before its result leaves.
// Reset is synchronous and clears the valid flags and the parse state.
// A held result only blocks a following final character; others keep flowing.
`default_nettype none

module color_string_parser #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_color_value,
   output logic [1:0]       rsp_parse_status
);
   import csp_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_value_ff;
   logic [1:0]     rsp_status_ff;
   logic           req_take;
   logic           step_go;
   csp_result_type step_result;

   assign step_go   = in_valid_ff && !(in_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !step_go;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (step_go ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (step_go && step_result.valid) ? 1'b1 :
                         (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;

   csp_step #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .enable    (step_go),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
      if (step_go && step_result.valid) begin
         rsp_value_ff  <= step_result.value;
         rsp_status_ff <= step_result.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_color_value  = rsp_value_ff;
   assign rsp_parse_status = rsp_status_ff;

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked final transaction");

   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      (step_go && in_last_ff) |=> rsp_valid)
      else $error("final character produced no result");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !(step_go && in_last_ff)) |=> !rsp_valid)
      else $error("result repeated after being taken");

   a_malformed_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_parse_status == ST_MALFORMED || rsp_parse_status == ST_NO_DIGITS))
      |-> (rsp_color_value == 32'd0))
      else $error("non-zero value with failing status");

endmodule

`default_nettype wire

// ===== verif/color_parse_checker.sv =====
// Transaction monitor for the colour string parser: predicts each result and compares it.
module color_parse_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_color_value,
   input  logic [1:0]  rsp_parse_status,
   output int          fail_count,
   output int          pending_results,
   output int          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import csp_pkg::*;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } color_result_type;

   logic [3:0]       phase;
   logic [2:0]       ppos;
   logic [31:0]      packed_v;
   logic [31:0]      comp_v;
   logic [2:0]       cidx;
   logic [1:0]       nbase;
   logic             seen;
   logic             err;
   color_result_type expected_colors[$];
   color_result_type predicted;
   color_result_type oldest;
   bit               string_done;

   function automatic bit ws_char(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
   endfunction

   function automatic int base_radix(input logic [1:0] b);
      case (b)
         BASE_HEX: return 16;
         BASE_OCT: return 8;
         BASE_BIN: return 2;
         default:  return 10;
      endcase
   endfunction

   // 16 when the character is no digit of the base
   function automatic int digit_value(input logic [7:0] c, input logic [1:0] b);
      int         d;
      logic [7:0] l;
      l = fold_case(c);
      d = 16;
      if (c >= "0" && c <= "9") begin
         d = int'(c) - int'("0");
      end else if (l >= "a" && l <= "f") begin
         d = int'(l) - int'("a") + 10;
      end
      if (d >= base_radix(b)) begin
         d = 16;
      end
      return d;
   endfunction

   function automatic bit last_component();
      return int'(cidx) + 2 == int'(ppos);
   endfunction

   function automatic void accumulate(input int d);
      longint unsigned r;
      longint unsigned m;
      longint unsigned v;
      r = longint'(base_radix(nbase));
      m = 64'h0000_0000_FFFF_FFFF;
      v = comp_v;
      if (v > (m - longint'(d)) / r) begin
         comp_v = '1;
      end else begin
         comp_v = 32'(v * r + longint'(d));
      end
      seen = 1'b1;
   endfunction

   function automatic void begin_number(input logic [7:0] c);
      logic [7:0] l;
      l = fold_case(c);
      comp_v = '0;
      seen   = 1'b0;
      nbase  = BASE_DEC;
      if (c == "0") begin
         seen  = 1'b1;
         phase = PH_ZERO;
      end else if (l == "x") begin
         nbase = BASE_HEX;
         phase = PH_PREFIX;
      end else if (l == "o") begin
         nbase = BASE_OCT;
         phase = PH_PREFIX;
      end else if (l == "b") begin
         nbase = BASE_BIN;
         phase = PH_PREFIX;
      end else if (c >= "1" && c <= "9") begin
         accumulate(int'(c) - int'("0"));
         phase = PH_DIGITS;
      end else begin
         phase = PH_TRAIL;
      end
   endfunction

   function automatic void close_component();
      if (!(phase inside {PH_DIGITS, PH_ZERO, PH_PREFIX, PH_TOKWS})) begin
         err   = 1'b1;
         phase = PH_DONE;
         return;
      end
      packed_v = {packed_v[23:0], 8'h00} + comp_v;
      phase    = last_component() ? PH_DONE : PH_SKIP;
      cidx     = cidx + 3'd1;
      comp_v   = '0;
      seen     = 1'b0;
      nbase    = BASE_DEC;
   endfunction

   function automatic void clear_state();
      phase    = PH_WS;
      ppos     = '0;
      packed_v = '0;
      comp_v   = '0;
      cidx     = '0;
      nbase    = BASE_DEC;
      seen     = 1'b0;
      err      = 1'b0;
   endfunction

   function automatic void parse_char(input logic [7:0] c, input logic last,
                                      output bit produced, output color_result_type res);
      logic [7:0] l;
      logic [7:0] delim;
      int         d;
      string      pat;
      l        = fold_case(c);
      delim    = last_component() ? ")" : ",";
      produced = 1'b0;
      res      = '0;
      case (phase)
         PH_WS: begin
            if (!ws_char(c)) begin
               if (l == "r") begin
                  phase = PH_MATCH_RGB;
                  ppos  = 3'd1;
               end else if (l == "a") begin
                  phase = PH_MATCH_ARG;
                  ppos  = 3'd1;
               end else begin
                  begin_number(c);
               end
            end
         end
         PH_MATCH_RGB, PH_MATCH_ARG: begin
            if (phase == PH_MATCH_RGB) begin
               pat = "rgb(";
            end else begin
               pat = "argb(";
            end
            if (l == pat[ppos]) begin
               ppos = ppos + 3'd1;
               if (int'(ppos) >= pat.len()) begin
                  phase = PH_SKIP;
                  cidx  = '0;
               end
            end else begin
               ppos  = '0;
               phase = PH_NODIG;
            end
         end
         PH_SKIP: begin
            if (c != delim) begin
               phase = PH_TOKWS;
               if (!ws_char(c)) begin
                  begin_number(c);
               end
            end
         end
         PH_TOKWS: begin
            if (c == delim) begin
               close_component();
            end else if (!ws_char(c)) begin
               begin_number(c);
            end
         end
         PH_ZERO, PH_ZERO_X, PH_PREFIX, PH_PREFIX_WS, PH_DIGITS, PH_TRAIL: begin
            if (ppos != 0 && c == delim) begin
               close_component();
            end else begin
               case (phase)
                  PH_ZERO: begin
                     if (l == "x") begin
                        phase = PH_ZERO_X;
                     end else begin
                        d = digit_value(c, BASE_DEC);
                        if (d < 16) begin
                           accumulate(d);
                           phase = PH_DIGITS;
                        end else begin
                           phase = PH_TRAIL;
                        end
                     end
                  end
                  PH_ZERO_X: begin
                     d = digit_value(c, BASE_HEX);
                     if (d < 16) begin
                        nbase = BASE_HEX;
                        accumulate(d);
                        phase = PH_DIGITS;
                     end else begin
                        phase = PH_TRAIL;
                     end
                  end
                  PH_PREFIX, PH_PREFIX_WS: begin
                     if (ws_char(c)) begin
                        phase = PH_PREFIX_WS;
                     end else begin
                        d = digit_value(c, nbase);
                        if (d < 16) begin
                           accumulate(d);
                           phase = PH_DIGITS;
                        end else begin
                           phase = PH_TRAIL;
                        end
                     end
                  end
                  PH_DIGITS: begin
                     d = digit_value(c, nbase);
                     if (d < 16) begin
                        accumulate(d);
                     end else begin
                        phase = PH_TRAIL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase

      if (last) begin
         produced = 1'b1;
         if (phase inside {PH_WS, PH_MATCH_RGB, PH_MATCH_ARG, PH_NODIG}) begin
            res.value  = '0;
            res.status = ST_NO_DIGITS;
         end else if (ppos != 0) begin
            if (!err && phase != PH_DONE && phase != PH_SKIP && last_component()) begin
               close_component();
            end
            if (!err && phase == PH_DONE) begin
               res.value  = packed_v;
               res.status = ST_OK;
            end else begin
               res.value  = '0;
               res.status = ST_MALFORMED;
            end
         end else begin
            res.value = comp_v;
            if (phase == PH_DIGITS || phase == PH_ZERO) begin
               res.status = ST_OK;
            end else if (phase == PH_ZERO_X) begin
               res.status = ST_TRAILING;
            end else if (phase == PH_TRAIL) begin
               res.status = seen ? ST_TRAILING : ST_NO_DIGITS;
            end else begin
               res.status = ST_NO_DIGITS;
            end
         end
         clear_state();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_colors.delete();
         fail_count      = 0;
         results_checked = 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_char(req_char_code, req_last_char, string_done, predicted);
            if (string_done) begin
               expected_colors.push_back(predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               report_mismatch("unexpected result", rsp_color_value, '0);
            end else begin
               oldest = expected_colors.pop_front();
               results_checked++;
               if (rsp_color_value !== oldest.value) begin
                  report_mismatch("colour value", rsp_color_value, oldest.value);
               end
               if (rsp_parse_status !== oldest.status) begin
                  report_mismatch("parse status", 32'(rsp_parse_status), 32'(oldest.status));
               end
            end
         end
      end
      pending_results = expected_colors.size();
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the colour string parser: clock, reset, string stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_CHARS    = 125;
   localparam int DRAIN_CYCLES   = 10;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [31:0] rsp_color_value;
   logic [1:0]  rsp_parse_status;

   int fail_count;
   int pending_results;
   int results_checked;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int chars_sent    = 0;
   int strings_sent  = 0;
   int quiet_cycles  = 0;
   int hold_left     = 0;
   bit hold_token    = 1'b0;
   bit hold_seen     = 1'b0;

   color_string_parser i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_char_code,
      .req_last_char,
      .rsp_valid,
      .rsp_stall,
      .rsp_color_value,
      .rsp_parse_status
   );

   color_parse_checker i_checker (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_char_code,
      .req_last_char,
      .rsp_valid,
      .rsp_stall,
      .rsp_color_value,
      .rsp_parse_status,
      .fail_count,
      .pending_results,
      .results_checked
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: random stall, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic void push_text(ref byte unsigned s[$], input string t, input bit mix);
      byte unsigned c;
      for (int i = 0; i < t.len(); i++) begin
         c = t[i];
         if (mix && (c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 1)) begin
            c = c ^ 8'h20;
         end
         s.push_back(c);
      end
   endfunction

   function automatic void push_space(ref byte unsigned s[$], input int most);
      int k;
      repeat ($urandom_range(0, most)) begin
         k = $urandom_range(0, 5);
         s.push_back(k == 5 ? 8'h20 : 8'(8'h09 + k));
      end
   endfunction

   function automatic void push_digits(ref byte unsigned s[$], input int count,
                                       input int radix);
      string glyphs;
      int    k;
      glyphs = "0123456789abcdef";
      repeat (count) begin
         k = $urandom_range(0, radix - 1);
         push_text(s, glyphs.substr(k, k), 1);
      end
   endfunction

   function automatic void push_number(ref byte unsigned s[$]);
      int k;
      case ($urandom_range(0, 9))
         0, 1, 2: push_text(s, $sformatf("%0d", $urandom_range(0, 255)), 0);
         3: begin
            push_text(s, $sformatf("%0d", $urandom_range(1, 9)), 0);
            push_digits(s, $urandom_range(0, 13), 10);
         end
         4: begin
            push_text(s, "0x", 1);
            push_digits(s, $urandom_range(1, 9), 16);
         end
         5: begin
            push_text(s, "x", 1);
            push_digits(s, $urandom_range(0, 9), 16);
         end
         6: begin
            push_text(s, "o", 1);
            push_digits(s, $urandom_range(0, 12), 8);
         end
         7: begin
            push_text(s, "b", 1);
            push_digits(s, $urandom_range(0, 34), 2);
         end
         8: begin
            k = $urandom_range(0, 2);
            push_text(s, k == 0 ? "x" : k == 1 ? "o" : "b", 1);
            push_space(s, 2);
            push_digits(s, $urandom_range(0, 3), k == 0 ? 16 : k == 1 ? 8 : 2);
         end
         default: begin
            s.push_back("0");
            k = $urandom_range(0, 2);
            if (k == 1) begin
               push_text(s, "x", 1);
            end else if (k == 2) begin
               push_digits(s, $urandom_range(1, 3), 10);
            end
         end
      endcase
   endfunction

   function automatic void make_string(ref byte unsigned s[$]);
      int    kind;
      int    ncomp;
      int    cut;
      bit    argb;
      string pre;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         push_space(s, 1);
         argb = $urandom_range(0, 1);
         if (argb) begin
            push_text(s, "argb(", 1);
         end else begin
            push_text(s, "rgb(", 1);
         end
         ncomp = argb ? 4 : 3;
         if ($urandom_range(0, 9) == 0) begin
            ncomp = $urandom_range(1, 5);
         end
         for (int i = 0; i < ncomp; i++) begin
            if (i == ncomp - 1 && $urandom_range(0, 7) == 0) begin
               s.push_back(")");
            end
            push_space(s, 1);
            if ($urandom_range(0, 11) != 0) begin
               push_number(s);
            end
            if ($urandom_range(0, 14) == 0) begin
               s.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 5) == 0) begin
               push_space(s, 2);
            end
            if (i < ncomp - 1) begin
               s.push_back(",");
               if ($urandom_range(0, 7) == 0) begin
                  s.push_back(",");
               end
            end
         end
         case ($urandom_range(0, 5))
            0: ;
            1: push_text(s, "))", 0);
            2: begin
               s.push_back(")");
               repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(32, 126)));
            end
            default: s.push_back(")");
         endcase
         if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, s.size());
            while (s.size() > cut) void'(s.pop_back());
         end
      end else if (kind < 70) begin
         push_space(s, 2);
         push_number(s);
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(33, 126)));
         end
      end else if (kind < 82) begin
         push_space(s, 1);
         if ($urandom_range(0, 1)) begin
            pre = "argb(";
            push_text(s, pre.substr(0, $urandom_range(0, 3)), 1);
         end else begin
            pre = "rgb(";
            push_text(s, pre.substr(0, $urandom_range(0, 2)), 1);
         end
         if ($urandom_range(0, 1)) begin
            s.push_back(8'($urandom_range(32, 126)));
         end
      end else begin
         repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
      end
      if (s.size() == 0) begin
         s.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // caller is just past a falling edge; returns just past the one after the character is taken
   task automatic send_char(input byte unsigned c, input bit last);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_bytes(input byte unsigned s[$]);
      foreach (s[i]) begin
         send_char(s[i], i == s.size() - 1);
      end
      strings_sent++;
   endtask

   task automatic send_text(input string t);
      byte unsigned q[$];
      push_text(q, t, 0);
      send_bytes(q);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   initial begin
      byte unsigned text[$];
      int           req_pcts[4];
      int           rsp_pcts[4];
      int           phase_start;
      req_pcts = '{0, 67, 0, 26};
      rsp_pcts = '{0, 0, 67, 26};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      text.push_back(8'h00);
      send_bytes(text);
      send_text("\xFF");
      send_text("0");
      send_text("\t7");
      send_text("0X1f");
      send_text("b101");
      send_text("o17z");
      send_text("x");
      send_text("99999999999");
      send_text("rgb(1,2,3)");
      send_text("ARGB(255,,x10,b1,o7)");
      send_text("rgb(1,2");
      send_text("rgb(4y,5,6)");
      send_text("rgz");
      send_text("rgb(1,2,3)q");
      send_text("0x");
      send_text("rgb(b ,1,2)");
      send_text("rgb( ,1,))2");
      send_text("-5");
      wait_drained();

      // long hold-off on results while short strings are offered and stall behind it
      hold_token <= ~hold_token;
      repeat (24) send_text($sformatf("%0d", $urandom_range(0, 9)));
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         req_idle_pct  = req_pcts[p];
         rsp_stall_pct <= rsp_pcts[p];
         phase_start   = chars_sent;
         while (chars_sent < phase_start + PHASE_CHARS) begin
            text.delete();
            make_string(text);
            send_bytes(text);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d characters in %0d strings: plain numbers, rgb/argb, broken and noise",
               chars_sent, strings_sent);
      $display("Compared %0d results over four idle/stall mixes, a result hold-off and drains",
               results_checked);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
